[design/unwe_pkg.sv]
// ============================================================================
// unwe_pkg
// Shared types, codes and helpers of the UMI nucleotide word encoder.
// ============================================================================
`default_nettype none

package unwe_pkg;

    // Fixed limits of the block
    localparam int TAKE_MAX   = 32;
    localparam int MAX_READS  = 4;
    localparam int RESULT_CAP = 32;
    localparam int TAKE_LIM   = (TAKE_MAX < RESULT_CAP) ? TAKE_MAX : RESULT_CAP;

    // Position / size counters hold values up to RESULT_CAP
    localparam int POS_W      = 6;
    localparam int RIDX_W     = 2;
    localparam int CNT_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;

    // Input actions
    localparam logic [1:0] ACT_HDR_BYTE = 2'd0;
    localparam logic [1:0] ACT_HDR_END  = 2'd1;
    localparam logic [1:0] ACT_SEQ_BYTE = 2'd2;
    localparam logic [1:0] ACT_READ_END = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_SIZE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAKE0      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAKE1      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TAKE2      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TAKE3      = 3'd5;

    // Characters
    localparam logic [7:0] CH_A          = 8'h41;
    localparam logic [7:0] CH_C          = 8'h43;
    localparam logic [7:0] CH_G          = 8'h47;
    localparam logic [7:0] CH_T          = 8'h54;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_SPACE      = 8'h20;

    // Nucleotide codes
    localparam logic [1:0] CODE_A   = 2'd0;
    localparam logic [1:0] CODE_C   = 2'd1;
    localparam logic [1:0] CODE_G   = 2'd2;
    localparam logic [1:0] CODE_T   = 2'd3;
    localparam logic [1:0] CODE_PAD = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_byte;
    } in_beat_t;

    typedef struct packed {
        logic [1:0] code;
        logic       code_valid;
        logic       filtered;
        logic       word_end;
    } out_beat_t;

    typedef struct packed {
        logic [1:0] code;
        logic       ok;
    } nt_enc_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UMI,
        ST_PAD
    } ctrl_state_t;

    // Controller -> datapath
    typedef struct packed {
        logic accept;
        logic umi_step;
        logic pad_step;
    } dp_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic out_free;
        logic umi_go;
        logic pad_go;
        logic umi_done;
        logic pad_done;
    } dp_status_t;

    // Datapath -> field tracker
    typedef struct packed {
        logic       clear;
        logic       byte_en;
        logic       is_delim;
        logic       code_ok;
        logic [1:0] code;
    } trk_cmd_t;

    function automatic nt_enc_t encode_nt(input logic [7:0] ch);
        nt_enc_t r;
        r.ok = 1'b1;
        unique case (ch)
            CH_A:    r.code = CODE_A;
            CH_C:    r.code = CODE_C;
            CH_G:    r.code = CODE_G;
            CH_T:    r.code = CODE_T;
            default:
            begin
                r.code = CODE_PAD;
                r.ok   = 1'b0;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

[design/unwe_stream_if.sv]
// ============================================================================
// unwe_stream_if
// Valid/ready stream channel carrying one payload beat per handshake.
// ============================================================================
`default_nettype none

interface unwe_stream_if #(parameter type payload_t = logic);

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

[design/unwe_field_trk.sv]
// ============================================================================
// unwe_field_trk
// Tracks one delimited header field: length, seen and clean flags, and a
// small code RAM with a registered read port.
// ============================================================================
`default_nettype none

module unwe_field_trk
    import unwe_pkg::*;
#(
    parameter int UMI_MAX = 32
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire trk_cmd_t                           cmd,
    input  wire logic [POS_W-1:0]                   rd_addr,
    output logic                                    usable,
    output logic [$clog2(UMI_MAX+1)-1:0]            len,
    output logic [1:0]                              rd_data
);

    localparam int LW = $clog2(UMI_MAX + 1);
    localparam int AW = (UMI_MAX > 1) ? $clog2(UMI_MAX) : 1;

    logic [1:0]    mem [UMI_MAX];
    logic [1:0]    rd_data_reg;
    logic [LW-1:0] len_reg, len_next;
    logic          seen_reg, seen_next;
    logic          clean_reg, clean_next;
    logic          append;
    logic          wr_en;

    always_comb
    begin
        len_next   = len_reg;
        seen_next  = seen_reg;
        clean_next = clean_reg;
        append     = cmd.byte_en && !cmd.is_delim && seen_reg;
        wr_en      = append && (len_reg < LW'(UMI_MAX));
        if (cmd.clear)
        begin
            len_next   = '0;
            seen_next  = 1'b0;
            clean_next = 1'b1;
        end
        else if (cmd.byte_en && cmd.is_delim)
        begin
            len_next   = '0;
            seen_next  = 1'b1;
            clean_next = 1'b1;
        end
        else if (append)
        begin
            if (!cmd.code_ok)
            begin
                clean_next = 1'b0;
            end
            if (wr_en)
            begin
                len_next = len_reg + LW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            seen_reg  <= 1'b0;
            clean_reg <= 1'b1;
        end
        else
        begin
            len_reg   <= len_next;
            seen_reg  <= seen_next;
            clean_reg <= clean_next;
        end
    end

    // Field RAM: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[len_reg[AW-1:0]] <= cmd.code;
        end
        rd_data_reg <= mem[rd_addr[AW-1:0]];
    end

    assign usable  = seen_reg && (len_reg != '0) && clean_reg;
    assign len     = len_reg;
    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[design/unwe_datapath.sv]
// ============================================================================
// unwe_datapath
// Configuration registers, header field trackers, read position counters,
// word filter flag and the output beat register.
// ============================================================================
`default_nettype none

module unwe_datapath
    import unwe_pkg::*;
#(
    parameter int UMI_MAX = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire in_beat_t               in_beat,
    input  wire logic                   out_ready,
    input  wire dp_cmd_t                cmd,
    output dp_status_t                  status,
    output logic                        out_valid,
    output out_beat_t                   out_beat
);

    localparam int LW      = $clog2(UMI_MAX + 1);
    localparam int SizeLim = (UMI_MAX < RESULT_CAP) ? UMI_MAX : RESULT_CAP;

    // Configuration
    logic [POS_W-1:0]  hdr_size_reg;
    logic [CNT_W-1:0]  rd_count_reg;
    logic [POS_W-1:0]  take_reg [MAX_READS];

    // Record state
    logic [RIDX_W-1:0] read_idx_reg, read_idx_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              wf_reg, wf_next;
    logic              space_seen_reg, space_seen_next;
    logic [POS_W-1:0]  umi_idx_reg, umi_idx_next;
    logic [LW-1:0]     umi_len_reg, umi_len_next;
    logic              use_colon_reg, use_colon_next;

    // Output beat register
    logic              out_valid_reg;
    out_beat_t         out_beat_reg;

    nt_enc_t           enc;
    logic [POS_W-1:0]  take_raw, take_cur, umi_size;
    logic [CNT_W-1:0]  count_eff;
    logic              last_read, pos_lt_take, hdr_ok;
    logic              is_hdr, is_eoh, is_seq, is_eor;
    logic              hdr_en, eoh_en, seq_en, eor_now, pad_fin, word_fin, hdr_clear;
    logic              umi_pad;
    logic              emit;
    out_beat_t         emit_beat;
    trk_cmd_t          us_cmd, co_cmd;
    logic              us_usable, co_usable;
    logic [LW-1:0]     us_len, co_len;
    logic [1:0]        us_rd, co_rd;

    unwe_field_trk #(.UMI_MAX(UMI_MAX)) u_us_trk
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (us_cmd),
        .rd_addr (umi_idx_next),
        .usable  (us_usable),
        .len     (us_len),
        .rd_data (us_rd)
    );

    unwe_field_trk #(.UMI_MAX(UMI_MAX)) u_co_trk
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (co_cmd),
        .rd_addr (umi_idx_next),
        .usable  (co_usable),
        .len     (co_len),
        .rd_data (co_rd)
    );

    always_comb
    begin
        enc      = encode_nt(in_beat.char_byte);
        take_raw = take_reg[read_idx_reg];
        take_cur = (take_raw > POS_W'(TAKE_LIM)) ? POS_W'(TAKE_LIM) : take_raw;
        umi_size = (hdr_size_reg > POS_W'(SizeLim)) ? POS_W'(SizeLim) : hdr_size_reg;

        count_eff = rd_count_reg;
        if (rd_count_reg == '0)
        begin
            count_eff = CNT_W'(1);
        end
        else if (rd_count_reg > CNT_W'(MAX_READS))
        begin
            count_eff = CNT_W'(MAX_READS);
        end

        last_read   = ({1'b0, read_idx_reg} + CNT_W'(1)) >= count_eff;
        pos_lt_take = pos_reg < take_cur;
        hdr_ok      = (read_idx_reg == '0);

        is_hdr = (in_beat.action == ACT_HDR_BYTE);
        is_eoh = (in_beat.action == ACT_HDR_END);
        is_seq = (in_beat.action == ACT_SEQ_BYTE);
        is_eor = (in_beat.action == ACT_READ_END);

        status.out_free = !out_valid_reg || out_ready;
        status.umi_go   = is_eoh && hdr_ok && (umi_size != '0);
        status.pad_go   = is_eor && pos_lt_take;
        status.umi_done = ({1'b0, umi_idx_reg} + (POS_W+1)'(1)) >= {1'b0, umi_size};
        status.pad_done = ({1'b0, pos_reg} + (POS_W+1)'(1)) >= {1'b0, take_cur};

        hdr_en    = cmd.accept && is_hdr && hdr_ok && !space_seen_reg;
        eoh_en    = cmd.accept && is_eoh && hdr_ok;
        seq_en    = cmd.accept && is_seq && pos_lt_take;
        eor_now   = cmd.accept && is_eor && !pos_lt_take;
        pad_fin   = cmd.pad_step && status.pad_done;
        word_fin  = (eor_now || pad_fin) && last_read;
        hdr_clear = eoh_en || word_fin;

        // Tracker commands: both fields see every non-space header byte of read zero before its first space
        us_cmd.clear    = hdr_clear;
        us_cmd.byte_en  = hdr_en && (in_beat.char_byte != CH_SPACE);
        us_cmd.is_delim = (in_beat.char_byte == CH_UNDERSCORE);
        us_cmd.code_ok  = enc.ok;
        us_cmd.code     = enc.code;
        co_cmd          = us_cmd;
        co_cmd.is_delim = (in_beat.char_byte == CH_COLON);

        umi_pad = !(8'(umi_idx_reg) < 8'(umi_len_reg));

        // Result beat selection
        emit      = 1'b1;
        emit_beat = '0;
        priority if (seq_en)
        begin
            emit_beat.code       = enc.code;
            emit_beat.code_valid = 1'b1;
            emit_beat.filtered   = wf_reg || !enc.ok;
        end
        else if (cmd.umi_step)
        begin
            emit_beat.code       = umi_pad ? CODE_PAD : (use_colon_reg ? co_rd : us_rd);
            emit_beat.code_valid = 1'b1;
            emit_beat.filtered   = wf_reg || umi_pad;
        end
        else if (cmd.pad_step)
        begin
            emit_beat.code       = CODE_PAD;
            emit_beat.code_valid = 1'b1;
            emit_beat.filtered   = 1'b1;
            emit_beat.word_end   = last_read && status.pad_done;
        end
        else if (eor_now && last_read)
        begin
            emit_beat.filtered   = wf_reg;
            emit_beat.word_end   = 1'b1;
        end
        else
        begin
            emit = 1'b0;
        end

        // Word filter flag
        wf_next = wf_reg;
        priority if (word_fin)
        begin
            wf_next = 1'b0;
        end
        else if ((seq_en && !enc.ok) || (cmd.umi_step && umi_pad) || cmd.pad_step)
        begin
            wf_next = 1'b1;
        end
        else
        begin
            wf_next = wf_reg;
        end

        // Read position and read index
        pos_next      = pos_reg;
        read_idx_next = read_idx_reg;
        if (seq_en || (cmd.pad_step && !pad_fin))
        begin
            pos_next = pos_reg + POS_W'(1);
        end
        else if (pad_fin || eor_now)
        begin
            pos_next      = '0;
            read_idx_next = word_fin ? '0 : read_idx_reg + RIDX_W'(1);
        end

        space_seen_next = space_seen_reg;
        if (hdr_clear)
        begin
            space_seen_next = 1'b0;
        end
        else if (hdr_en && (in_beat.char_byte == CH_SPACE))
        begin
            space_seen_next = 1'b1;
        end

        // UMI source chosen at end of header: underscore field wins
        umi_idx_next   = umi_idx_reg;
        umi_len_next   = umi_len_reg;
        use_colon_next = use_colon_reg;
        if (eoh_en)
        begin
            umi_idx_next   = '0;
            use_colon_next = !us_usable;
            umi_len_next   = us_usable ? us_len : (co_usable ? co_len : '0);
        end
        else if (cmd.umi_step)
        begin
            umi_idx_next = umi_idx_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_size_reg   <= '0;
            rd_count_reg   <= CNT_W'(1);
            take_reg[0]    <= POS_W'(12);
            take_reg[1]    <= POS_W'(12);
            take_reg[2]    <= '0;
            take_reg[3]    <= '0;
            read_idx_reg   <= '0;
            pos_reg        <= '0;
            wf_reg         <= 1'b0;
            space_seen_reg <= 1'b0;
            umi_idx_reg    <= '0;
            umi_len_reg    <= '0;
            use_colon_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_HDR_SIZE:   hdr_size_reg <= cfg_data;
                    CFG_READ_COUNT: rd_count_reg <= cfg_data[CNT_W-1:0];
                    CFG_TAKE0:      take_reg[0]  <= cfg_data;
                    CFG_TAKE1:      take_reg[1]  <= cfg_data;
                    CFG_TAKE2:      take_reg[2]  <= cfg_data;
                    CFG_TAKE3:      take_reg[3]  <= cfg_data;
                    default:        ;
                endcase
            end
            read_idx_reg   <= read_idx_next;
            pos_reg        <= pos_next;
            wf_reg         <= wf_next;
            space_seen_reg <= space_seen_next;
            umi_idx_reg    <= umi_idx_next;
            umi_len_reg    <= umi_len_next;
            use_colon_reg  <= use_colon_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_beat_reg <= emit_beat;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    // A new beat never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (!out_valid_reg || out_ready))
        else $error("result beat overwritten");

    // Word end leaves the record state cleared
    a_word_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && emit_beat.word_end) |=> (read_idx_reg == '0 && !wf_reg && !space_seen_reg))
        else $error("record state not cleared after word end");

    a_pad_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pad_step |-> pos_lt_take)
        else $error("padding beyond take length");

    a_umi_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.umi_step |-> (8'(umi_idx_reg) < 8'(umi_size)))
        else $error("UMI index beyond size");

endmodule

`default_nettype wire

[design/unwe_ctrl.sv]
// ============================================================================
// unwe_ctrl
// Sequencer: accepts input beats when idle and walks UMI and padding runs.
// ============================================================================
`default_nettype none

module unwe_ctrl
    import unwe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire dp_status_t status,
    output logic            in_ready,
    output dp_cmd_t         cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = status.out_free;
                if (in_valid && status.out_free)
                begin
                    cmd.accept = 1'b1;
                    if (status.umi_go)
                    begin
                        state_next = ST_UMI;
                    end
                    else if (status.pad_go)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_UMI:
            begin
                if (status.out_free)
                begin
                    cmd.umi_step = 1'b1;
                    if (status.umi_done)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_PAD:
            begin
                if (status.out_free)
                begin
                    cmd.pad_step = 1'b1;
                    if (status.pad_done)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.umi_step, cmd.pad_step}))
        else $error("more than one datapath command");

endmodule

`default_nettype wire

[design/umi_nucleotide_word_encoder_unit.sv]
// ============================================================================
// umi_nucleotide_word_encoder_unit
// Builds one 2-bit nucleotide code word per record from a header/sequence
// character stream: UMI taken from the first header, then each read's bases.
// ============================================================================
//
//  Channel    Dir  Payload                                  Beat
//  ---------  ---  ---------------------------------------  ----------------
//  item_in    in   action[1:0], char_byte[7:0]              one stream event
//  word_out   out  code[1:0], code_valid, filtered,         one code of word
//                  word_end
//  cfg_*      in   cfg_index[2:0], cfg_data[5:0]            register write
//
//  Header bytes and sequence bytes are taken directly from the idle state.
//  End of header is taken, then N UMI codes follow from the UMI state; codes stream
//  one per cycle while the output is not stalled, from the registered read port of
//  the field RAM. End of read is taken, then P padding codes follow from the pad state.
//  A stalled output holds the result register and the sequencer; input is
//  taken only when idle and the result register is free or draining.
//  Reset clears control state and the header trackers; the field RAMs are not
//  cleared, since only entries below a field's length are ever used.
//
`default_nettype none

module umi_nucleotide_word_encoder_unit
    import unwe_pkg::*;
#(
    parameter int UMI_MAX = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    unwe_stream_if.sink                 item_in,
    unwe_stream_if.source               word_out
);

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_ready;
    logic       out_valid;
    out_beat_t  out_beat;
    in_beat_t   in_beat;

    // Unpack the input beat into the datapath's view
    assign in_beat = item_in.payload;

    // Sequencer: decides when a beat is taken and walks multi-code runs
    unwe_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item_in.valid),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    // Datapath: config, header trackers, counters and the output register
    unwe_datapath #(.UMI_MAX(UMI_MAX)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_beat   (in_beat),
        .out_ready (word_out.ready),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_beat  (out_beat)
    );

    assign item_in.ready    = in_ready;
    assign word_out.valid   = out_valid;
    assign word_out.payload = out_beat;

endmodule

`default_nettype wire

[tb/sv/umi_nucleotide_word_encoder_unit_checker.sv]
// ============================================================================
// umi_nucleotide_word_encoder_unit_checker
// Watches the configuration port and both stream channels of the word
// encoder, predicts the code beats of every accepted input beat and compares
// each accepted output beat with the oldest prediction.
// ============================================================================

module umi_nucleotide_word_encoder_unit_checker
    import unwe_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    unwe_stream_if                      item_mon,
    unwe_stream_if                      word_mon,
    output int                          mismatches,
    output int                          codes_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FIELD_MAX = 32;
    localparam int UMI_LIM   = (FIELD_MAX < RESULT_CAP) ? FIELD_MAX : RESULT_CAP;
    localparam int FLD_US    = 0;
    localparam int FLD_CO    = 1;

    // register copies
    logic [5:0] umi_size_reg;
    logic [2:0] reads_reg;
    logic [5:0] take_reg [MAX_READS];

    // header trackers: one for the '_' field, one for the ':' field
    logic [1:0] fld_codes [2][FIELD_MAX];
    int         fld_len   [2];
    bit         fld_seen  [2];
    bit         fld_clean [2];
    bit         past_space;

    int         read_idx;
    int         read_pos;
    bit         word_filt;

    out_beat_t  expected_codes [$];
    int         fail_count;

    function automatic int clip_len(input int v, input int lim);
        return (v > lim) ? lim : v;
    endfunction

    // {ok, code}
    function automatic logic [2:0] base_code(input logic [7:0] ch);
        if (ch == CH_A) return {1'b1, CODE_A};
        if (ch == CH_C) return {1'b1, CODE_C};
        if (ch == CH_G) return {1'b1, CODE_G};
        if (ch == CH_T) return {1'b1, CODE_T};
        return {1'b0, CODE_PAD};
    endfunction

    function automatic void clear_header();
        for (int f = 0; f < 2; f++)
        begin
            fld_len[f]   = 0;
            fld_seen[f]  = 1'b0;
            fld_clean[f] = 1'b1;
        end
        past_space = 1'b0;
    endfunction

    function automatic void reset_model();
        umi_size_reg = '0;
        reads_reg    = 3'd1;
        take_reg[0]  = 6'd12;
        take_reg[1]  = 6'd12;
        take_reg[2]  = 6'd0;
        take_reg[3]  = 6'd0;
        clear_header();
        read_idx  = 0;
        read_pos  = 0;
        word_filt = 1'b0;
    endfunction

    function automatic void push_code(input logic [1:0] c, input bit v, input bit last_beat);
        out_beat_t r;
        r.code       = c;
        r.code_valid = v;
        r.filtered   = word_filt;
        r.word_end   = last_beat;
        expected_codes = {expected_codes, r};
    endfunction

    function automatic void add_to_field(input int f, input logic [7:0] ch);
        logic [2:0] e;
        e = base_code(ch);
        if (!e[2])
            fld_clean[f] = 1'b0;
        // length saturates, the clean flag keeps tracking
        if (fld_len[f] < FIELD_MAX)
        begin
            fld_codes[f][fld_len[f]] = e[1:0];
            fld_len[f]++;
        end
    endfunction

    function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
        unique case (idx)
            CFG_HDR_SIZE:   umi_size_reg = val;
            CFG_READ_COUNT: reads_reg = val[2:0];
            CFG_TAKE0:      take_reg[0] = val;
            CFG_TAKE1:      take_reg[1] = val;
            CFG_TAKE2:      take_reg[2] = val;
            CFG_TAKE3:      take_reg[3] = val;
            default: ;
        endcase
    endfunction

    function automatic void predict_codes(input in_beat_t b);
        int         count;
        int         take;
        int         size;
        int         len;
        int         src;
        bit         last_read;
        int         n;
        logic [2:0] e;

        count = int'(reads_reg);
        if (count == 0)
            count = 1;
        if (count > MAX_READS)
            count = MAX_READS;
        take = clip_len(int'(take_reg[read_idx]), TAKE_LIM);

        unique case (b.action)
            ACT_HDR_BYTE:
            begin
                if (read_idx == 0 && !past_space)
                begin
                    if (b.char_byte == CH_SPACE)
                        past_space = 1'b1;
                    else
                    begin
                        if (b.char_byte == CH_UNDERSCORE)
                        begin
                            fld_seen[FLD_US]  = 1'b1;
                            fld_len[FLD_US]   = 0;
                            fld_clean[FLD_US] = 1'b1;
                        end
                        else if (fld_seen[FLD_US])
                            add_to_field(FLD_US, b.char_byte);
                        if (b.char_byte == CH_COLON)
                        begin
                            fld_seen[FLD_CO]  = 1'b1;
                            fld_len[FLD_CO]   = 0;
                            fld_clean[FLD_CO] = 1'b1;
                        end
                        else if (fld_seen[FLD_CO])
                            add_to_field(FLD_CO, b.char_byte);
                    end
                end
            end
            ACT_HDR_END:
            begin
                if (read_idx == 0)
                begin
                    size = clip_len(int'(umi_size_reg), UMI_LIM);
                    src  = FLD_US;
                    len  = 0;
                    if (fld_seen[FLD_US] && fld_len[FLD_US] > 0 && fld_clean[FLD_US])
                        len = fld_len[FLD_US];
                    else if (fld_seen[FLD_CO] && fld_len[FLD_CO] > 0 && fld_clean[FLD_CO])
                    begin
                        src = FLD_CO;
                        len = fld_len[FLD_CO];
                    end
                    for (int i = 0; i < size; i++)
                    begin
                        if (i < len)
                            push_code(fld_codes[src][i], 1'b1, 1'b0);
                        else
                        begin
                            word_filt = 1'b1;
                            push_code(CODE_PAD, 1'b1, 1'b0);
                        end
                    end
                    clear_header();
                end
            end
            ACT_SEQ_BYTE:
            begin
                if (read_pos < take)
                begin
                    e = base_code(b.char_byte);
                    if (!e[2])
                        word_filt = 1'b1;
                    read_pos++;
                    push_code(e[1:0], 1'b1, 1'b0);
                end
            end
            default:
            begin
                last_read = (read_idx + 1) >= count;
                n = 0;
                while (read_pos < take)
                begin
                    read_pos++;
                    word_filt = 1'b1;
                    push_code(CODE_PAD, 1'b1, last_read && read_pos >= take);
                    n++;
                end
                if (last_read)
                begin
                    // a word that needs no padding still closes with a marker beat
                    if (n == 0)
                        push_code(CODE_A, 1'b0, 1'b1);
                    clear_header();
                    read_idx  = 0;
                    word_filt = 1'b0;
                end
                else
                    read_idx = (read_idx + 1) % MAX_READS;
                read_pos = 0;
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        in_beat_t  beat;
        out_beat_t got;
        out_beat_t want;
        if (!rst_n)
        begin
            reset_model();
            expected_codes.delete();
            fail_count = 0;
            mismatches    <= 0;
            codes_pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                apply_config(cfg_index, cfg_data);
            if (item_mon.valid && item_mon.ready)
            begin
                beat = item_mon.payload;
                predict_codes(beat);
            end
            if (word_mon.valid && word_mon.ready)
            begin
                got = word_mon.payload;
                if (expected_codes.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected code beat code %0d valid %0b filt %0b end %0b",
                                 $realtime, got.code, got.code_valid, got.filtered,
                                 got.word_end);
                end
                else
                begin
                    want = expected_codes.pop_front();
                    if (got.code !== want.code || got.code_valid !== want.code_valid ||
                        got.filtered !== want.filtered || got.word_end !== want.word_end)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: code beat mismatch: expected code %0d valid %0b ",
                                      "filt %0b end %0b, got code %0d valid %0b filt %0b ",
                                      "end %0b"},
                                     $realtime, want.code, want.code_valid, want.filtered,
                                     want.word_end, got.code, got.code_valid, got.filtered,
                                     got.word_end);
                    end
                end
            end
            mismatches    <= fail_count;
            codes_pending <= expected_codes.size();
        end
    end

endmodule

[tb/sv/umi_nucleotide_word_encoder_unit_test.sv]
// ============================================================================
// umi_nucleotide_word_encoder_unit_test
// Drives header and sequence character streams into the word encoder under
// several register settings, with bursty input and a stalling receiver,
// and reports the checker's verdict.
// ============================================================================

module umi_nucleotide_word_encoder_unit_test
    import unwe_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         CYCLE_LIMIT  = 300000;
    localparam int         PHASE_BEATS  = 20;
    localparam int         PHASE_COUNT  = 10;
    localparam logic [7:0] CH_N         = 8'h4E;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     mismatches;
    int                     codes_pending;
    int                     cycle_count = 0;

    // sender burst state and a shadow of the register settings
    int                     burst_left  = 0;
    int                     beats_sent  = 0;
    int                     cur_count   = 1;
    int                     cur_take [MAX_READS] = '{12, 12, 0, 0};

    // receiver stall pattern
    int                     ready_mode  = 0;
    int                     ready_span  = 0;

    unwe_stream_if #(.payload_t(in_beat_t))  item_in ();
    unwe_stream_if #(.payload_t(out_beat_t)) word_out ();

    umi_nucleotide_word_encoder_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item_in   (item_in),
        .word_out  (word_out)
    );

    umi_nucleotide_word_encoder_unit_checker scoreboard
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_mon      (item_in),
        .word_mon      (word_out),
        .mismatches    (mismatches),
        .codes_pending (codes_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Abort a hung run; the limit sits far above the slowest legal run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("umi_nucleotide_word_encoder_unit test failed");
            $finish;
        end
    end

    // Receiver: switch between always ready, light stalls, heavy stalls and a
    // periodic pattern, each held for a random span of cycles.
    always @(posedge clk)
    begin
        if (ready_span == 0)
        begin
            ready_mode <= $urandom_range(0, 3);
            ready_span <= $urandom_range(8, 80);
        end
        else
            ready_span <= ready_span - 1;
        unique case (ready_mode)
            0:       word_out.ready <= 1'b1;
            1:       word_out.ready <= ($urandom_range(0, 3) != 0);
            2:       word_out.ready <= ($urandom_range(0, 4) == 0);
            default: word_out.ready <= ((cycle_count % 7) < 3);
        endcase
    end

    // Send one beat. Bursts of random length alternate with random gaps; a
    // long burst now and then gives stretches without any idle cycle.
    task automatic send_beat(input logic [1:0] act, input logic [7:0] ch);
        in_beat_t b;
        int       gap;
        b.action    = act;
        b.char_byte = ch;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                item_in.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        item_in.valid   <= 1'b1;
        item_in.payload <= b;
        do
            @(posedge clk);
        while (!item_in.ready);
        beats_sent++;
    endtask

    // Drop valid and hold off until every predicted code beat has come out,
    // then allow a few cycles for a beat that makes no code.
    task automatic drain_codes();
        item_in.valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (codes_pending != 0);
        repeat (4) @(posedge clk);
    endtask

    // Write all six registers, one per cycle, then drop the write enable.
    task automatic program_config(input int hdr, input int cnt,
                                  input int t0, input int t1, input int t2, input int t3);
        logic [CFG_IDX_W-1:0]  idx  [6];
        int                    vals [6];
        idx  = '{CFG_HDR_SIZE, CFG_READ_COUNT, CFG_TAKE0, CFG_TAKE1, CFG_TAKE2, CFG_TAKE3};
        vals = '{hdr, cnt, t0, t1, t2, t3};
        for (int i = 0; i < 6; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i][CFG_DATA_W-1:0];
            @(posedge clk);
        end
        cfg_wr_en <= 1'b0;
        cur_count = cnt & 7;
        if (cur_count == 0)
            cur_count = 1;
        if (cur_count > MAX_READS)
            cur_count = MAX_READS;
        cur_take = '{t0, t1, t2, t3};
    endtask

    // Mostly a clean base; one in 'odds' is any byte, one in 'odds' is N.
    function automatic logic [7:0] pick_base(input int odds);
        int r;
        r = $urandom_range(0, odds - 1);
        if (r == 0)
            return 8'($urandom_range(0, 255));
        if (r == 1)
            return CH_N;
        unique case ($urandom_range(0, 3))
            0:       return CH_A;
            1:       return CH_C;
            2:       return CH_G;
            default: return CH_T;
        endcase
    endfunction

    // Header: a short name, then a few '_' or ':' fields, sometimes a long one
    // to hit the length cap, then maybe a space and trailing bytes.
    task automatic send_header();
        int segs;
        int n;
        int kind;
        repeat ($urandom_range(0, 3))
            send_beat(ACT_HDR_BYTE, 8'($urandom_range(8'h61, 8'h7A)));
        segs = $urandom_range(0, 3);
        repeat (segs)
        begin
            kind = $urandom_range(0, 2);
            if (kind == 0)
                send_beat(ACT_HDR_BYTE, CH_UNDERSCORE);
            else if (kind == 1)
                send_beat(ACT_HDR_BYTE, CH_COLON);
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 10);
            repeat (n)
                send_beat(ACT_HDR_BYTE, pick_base(10));
        end
        if ($urandom_range(0, 1) == 1)
        begin
            send_beat(ACT_HDR_BYTE, CH_SPACE);
            repeat ($urandom_range(0, 4))
                send_beat(ACT_HDR_BYTE, 8'($urandom_range(0, 255)));
        end
        send_beat(ACT_HDR_END, 8'($urandom_range(0, 255)));
    endtask

    // One read: sequence length near the take length, short or long of it.
    task automatic send_read(input int r);
        int take;
        int len;
        take = (cur_take[r] > TAKE_LIM) ? TAKE_LIM : cur_take[r];
        len  = ($urandom_range(0, 1) == 1) ? take : $urandom_range(0, take + 3);
        if (r != 0 && $urandom_range(0, 7) == 0)
        begin
            // headers of later reads should be ignored
            send_beat(ACT_HDR_BYTE, pick_base(4));
            send_beat(ACT_HDR_END, 8'($urandom_range(0, 255)));
        end
        repeat (len)
            send_beat(ACT_SEQ_BYTE, pick_base(16));
        send_beat(ACT_READ_END, 8'($urandom_range(0, 255)));
    endtask

    // A record; a partial one stops after read zero and, when there is more than one
    // read, leaves the read index advanced for whatever follows.
    task automatic send_record(input bit partial);
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 4))
                send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        send_header();
        for (int r = 0; r < cur_count; r++)
        begin
            send_read(r);
            if (partial)
                break;
        end
    endtask

    initial
    begin : stimulus
        int phase_end;
        int hdr;
        int cnt;

        rst_n          <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_index      <= CFG_HDR_SIZE;
        cfg_data       <= '0;
        item_in.valid   <= 1'b0;
        item_in.payload <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: UMI of 4 with two reads of 3 and 2 bases.
        program_config(4, 2, 3, 2, 0, 0);
        // ':' field then a '_' field that wins and gets N-padded
        send_beat(ACT_HDR_BYTE, CH_COLON);
        send_beat(ACT_HDR_BYTE, CH_G);
        send_beat(ACT_HDR_BYTE, CH_UNDERSCORE);
        send_beat(ACT_HDR_BYTE, CH_A);
        send_beat(ACT_HDR_BYTE, CH_T);
        send_beat(ACT_HDR_BYTE, CH_SPACE);
        send_beat(ACT_HDR_BYTE, CH_C);
        send_beat(ACT_HDR_END, 8'h00);
        // bytes at both extremes, then one past the take length
        send_beat(ACT_SEQ_BYTE, CH_A);
        send_beat(ACT_SEQ_BYTE, 8'hFF);
        send_beat(ACT_SEQ_BYTE, 8'h00);
        send_beat(ACT_SEQ_BYTE, CH_T);
        send_beat(ACT_READ_END, 8'hFF);
        // header of read one is ignored; its end of read pads one code
        send_beat(ACT_HDR_BYTE, CH_A);
        send_beat(ACT_HDR_END, 8'hFF);
        send_beat(ACT_SEQ_BYTE, CH_G);
        send_beat(ACT_READ_END, 8'h00);
        // repeated end of header gives an all-padding UMI both times
        send_beat(ACT_HDR_END, 8'h55);
        send_beat(ACT_HDR_END, 8'hAA);
        send_beat(ACT_SEQ_BYTE, CH_C);
        send_beat(ACT_SEQ_BYTE, CH_G);
        send_beat(ACT_READ_END, 8'h0F);
        // full last read: word end comes as a marker beat without a code
        send_beat(ACT_SEQ_BYTE, CH_A);
        send_beat(ACT_SEQ_BYTE, CH_C);
        send_beat(ACT_READ_END, 8'hF0);
        drain_codes();

        // Random phases; register writes only between drained phases.
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:       program_config(0, 0, 0, 0, 0, 0);
                1:       program_config(63, 7, 63, 32, 63, 32);
                2:       program_config(32, 4, 1, 2, 3, 4);
                default:
                begin
                    hdr = ($urandom_range(0, 4) == 0) ? 32 : $urandom_range(0, 10);
                    cnt = $urandom_range(0, 7);
                    program_config(hdr, cnt, $urandom_range(0, 10), $urandom_range(0, 10),
                                   $urandom_range(0, 10), $urandom_range(0, 10));
                end
            endcase
            phase_end = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_end)
                send_record($urandom_range(0, 5) == 0);
            drain_codes();
        end

        // let any stray beat show up before the verdict
        repeat (20) @(posedge clk);
        if (mismatches == 0 && codes_pending == 0)
            $display("umi_nucleotide_word_encoder_unit test passed");
        else
            $display("umi_nucleotide_word_encoder_unit test failed");
        $finish;
    end

endmodule
